// ===== sv/cdt_pkg.sv =====
// Package with the word types, codes and constants of the countdown timer.
`default_nettype none

package cdt_pkg;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;

    typedef enum logic [1:0] {
        OP_POLL    = 2'd0,
        OP_TICK    = 2'd1,
        OP_CAPTURE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [CfgIndexWidth-1:0] CFG_TICK_INCREMENT = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_ABORT_THRESHOLD = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_ADJUST_STEP = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_ADJUST_CEILING = 2'd3;

    localparam logic [15:0] MS_PER_SECOND       = 16'd1000;
    localparam logic [7:0]  RESET_SECONDS       = 8'd30;
    localparam logic [7:0]  RESET_TICK_INCR     = 8'd32;
    localparam logic [15:0] RESET_ABORT_THRESH  = 16'd1000;
    localparam logic [5:0]  RESET_ADJUST_STEP   = 6'd5;
    localparam logic [7:0]  RESET_ADJUST_CEIL   = 8'd250;

    typedef struct packed {
        logic [1:0]  op;
        logic        start_button;
        logic        stop_button;
        logic        up_button;
        logic        down_button;
        logic [15:0] capture_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] shown_seconds;
        logic [7:0] remaining_seconds;
        logic       alarm;
        logic       aborted;
        logic       counting;
    } out_word_t;

endpackage

`default_nettype wire

// ===== sv/countdown_timer_with_pulse_abort.sv =====
// Top level of the settable countdown timer with capture-based abort.
//
//  channel   direction  handshake                 payload
//  in        into       in_valid / in_stall       in_data  (cdt_pkg::in_word_t)
//  out       out of     out_valid / out_stall     out_data (cdt_pkg::out_word_t)
//  cfg       into       cfg_write                 cfg_index, cfg_data
//
// Each word is processed in the cycle it is accepted and its result is registered.
// One word can be accepted in every cycle while in_stall is low.
// A two-entry output stage (result register and skid register) lets a word be accepted
// while a result is stalled; in_stall rises only when both entries are full.
// Reset is asynchronous and restores every state and configuration register.
`default_nettype none

module countdown_timer_with_pulse_abort (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire cdt_pkg::in_word_t                in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output cdt_pkg::out_word_t                    out_data,
    input  wire logic                             cfg_write,
    input  wire logic [cdt_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [cdt_pkg::CfgDataWidth-1:0]  cfg_data
);
    import cdt_pkg::*;

    logic [7:0]  tick_incr_reg;
    logic [15:0] abort_thresh_reg;
    logic [5:0]  adjust_step_reg;
    logic [7:0]  adjust_ceil_reg;

    logic [7:0]  seconds_reg,   seconds_next;
    logic [15:0] elapsed_reg,   elapsed_next;
    logic        tick_en_reg,   tick_en_next;
    logic        counting_reg,  counting_next;
    logic [3:0]  buttons_reg,   buttons_next;
    logic [15:0] first_reg,     first_next;
    logic [15:0] second_reg,    second_next;
    logic        phase_reg,     phase_next;
    logic        alarm_reg,     alarm_next;
    logic [7:0]  display_reg,   display_next;

    logic        out_valid_reg;
    out_word_t   out_reg;
    logic        skid_valid_reg;
    out_word_t   skid_reg;

    logic        accept;
    logic        out_free;
    out_word_t   result;

    logic [3:0]  levels;
    logic [3:0]  rise;
    logic [8:0]  up_sum;
    logic [16:0] tick_sum;
    logic [15:0] diff_next;
    logic [7:0]  step_ext;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        seconds_next  = seconds_reg;
        elapsed_next  = elapsed_reg;
        tick_en_next  = tick_en_reg;
        counting_next = counting_reg;
        buttons_next  = buttons_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        phase_next    = phase_reg;
        alarm_next    = alarm_reg;
        display_next  = display_reg;
        levels   = {in_data.down_button, in_data.up_button,
                    in_data.stop_button, in_data.start_button};
        rise     = levels & ~buttons_reg;
        step_ext = {2'b00, adjust_step_reg};
        up_sum   = 9'd0;
        tick_sum = {1'b0, elapsed_reg} + {9'd0, tick_incr_reg};

        case (op_t'(in_data.op))
            OP_POLL:
            begin
                buttons_next = levels;
                if (rise[0])
                begin
                    tick_en_next  = 1'b1;
                    counting_next = 1'b1;
                end
                if (rise[1])
                begin
                    tick_en_next  = 1'b0;
                    counting_next = 1'b0;
                    elapsed_next  = 16'd0;
                end
                if (rise[2] && (seconds_next < adjust_ceil_reg))
                begin
                    up_sum       = {1'b0, seconds_next} + {1'b0, step_ext};
                    seconds_next = up_sum[8] ? 8'd255 : up_sum[7:0];
                end
                if (rise[3])
                begin
                    seconds_next = (step_ext > seconds_next) ? 8'd0
                                                             : seconds_next - step_ext;
                end
                if (elapsed_next >= MS_PER_SECOND)
                begin
                    if ((seconds_next != 8'd0) && counting_next)
                    begin
                        seconds_next = seconds_next - 8'd1;
                    end
                    if (seconds_next == 8'd0)
                    begin
                        alarm_next = 1'b1;
                    end
                    display_next = seconds_next;
                    elapsed_next = elapsed_next - MS_PER_SECOND;
                end
                if ((second_reg - first_reg) > abort_thresh_reg)
                begin
                    counting_next = 1'b0;
                end
            end
            OP_TICK:
            begin
                if (tick_en_reg)
                begin
                    elapsed_next = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
                end
            end
            OP_CAPTURE:
            begin
                if (phase_reg)
                begin
                    first_next = in_data.capture_value;
                end
                else
                begin
                    second_next = in_data.capture_value;
                end
                phase_next = !phase_reg;
            end
            default:
            begin
            end
        endcase

        diff_next = second_next - first_next;
        result.shown_seconds     = display_next;
        result.remaining_seconds = seconds_next;
        result.alarm             = alarm_next;
        result.aborted           = diff_next > abort_thresh_reg;
        result.counting          = counting_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_incr_reg    <= RESET_TICK_INCR;
            abort_thresh_reg <= RESET_ABORT_THRESH;
            adjust_step_reg  <= RESET_ADJUST_STEP;
            adjust_ceil_reg  <= RESET_ADJUST_CEIL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TICK_INCREMENT:  tick_incr_reg    <= cfg_data[7:0];
                CFG_ABORT_THRESHOLD: abort_thresh_reg <= cfg_data;
                CFG_ADJUST_STEP:     adjust_step_reg  <= cfg_data[5:0];
                CFG_ADJUST_CEILING:  adjust_ceil_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_reg  <= RESET_SECONDS;
            elapsed_reg  <= 16'd0;
            tick_en_reg  <= 1'b0;
            counting_reg <= 1'b0;
            buttons_reg  <= 4'd0;
            first_reg    <= 16'd0;
            second_reg   <= 16'd0;
            phase_reg    <= 1'b1;
            alarm_reg    <= 1'b0;
            display_reg  <= 8'd0;
        end
        else if (accept)
        begin
            seconds_reg  <= seconds_next;
            elapsed_reg  <= elapsed_next;
            tick_en_reg  <= tick_en_next;
            counting_reg <= counting_next;
            buttons_reg  <= buttons_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            phase_reg    <= phase_next;
            alarm_reg    <= alarm_next;
            display_reg  <= display_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cdt_checker.sv =====
// Port-level checker for the countdown timer, with its bind statement.
`default_nettype none

module cdt_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire cdt_pkg::out_word_t               out_data,
    input  wire logic                             cfg_write
);
    import cdt_pkg::*;

    logic alarm_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_seen_reg <= 1'b0;
        end
        else if (out_valid && out_data.alarm)
        begin
            alarm_seen_reg <= 1'b1;
        end
    end

    // A stalled result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result word changed or vanished");

    // The input side stalls only while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // Once an alarm has been reported, every later result reports it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alarm_seen_reg) |-> out_data.alarm)
        else $error("alarm cleared without reset");

    // A configuration write does not disturb a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && cfg_write && !in_valid) |=> $stable(out_data))
        else $error("configuration write changed a pending result");

endmodule

bind countdown_timer_with_pulse_abort cdt_checker u_cdt_checker (.*);

`default_nettype wire
